FILE: sv/gics_pkg.sv
// Package for the min-max contrast stretch block: payload words, sequencer
// states, register indexes and stretch constants. No dependencies.
`default_nettype none

package gics_pkg;

    // Command word taken on start
    typedef struct packed {
        logic        op;
        logic        start_frame;
        logic [15:0] pixel;
        logic [11:0] index;
    } t_cmd;

    // Result word shown for one cycle under o_valid
    typedef struct packed {
        logic [15:0] value;
        logic        error;
    } t_result;

    // Command op codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Register indexes (paddr bit 2)
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    localparam int        REG_BITS   = 7;
    localparam int        SIZE_BITS  = 2 * REG_BITS;
    localparam logic [6:0] ROWS_RESET = 7'd64;
    localparam logic [6:0] COLS_RESET = 7'd64;

    // round((v-min)*255/d) = floor(((v-min)*510 + d) / (2*d))
    localparam int STRETCH_TOP = 255;
    localparam int STRETCH_MUL = 2 * STRETCH_TOP;
    // quotient never exceeds 255, so eight restoring steps suffice
    localparam int QUOT_BITS   = 8;
    localparam int STEP_BITS   = 3;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FETCH = 3'b010,
        S_DIV   = 3'b100
    } t_state;

endpackage : gics_pkg

`default_nettype wire

FILE: sv/grey_image_contrast_stretch.sv
// Top level of the min-max contrast stretch block: pixel store, min/max
// tracking, APB register port and a shared restoring divider.
// Depends on gics_pkg.
//
// Loads never raise busy; they may come back to back. A read with error
// shows its result in the cycle after the accept edge. A flat-frame read shows
// its result after the store read; a stretched read after the store read, the
// numerator step and eight compare/subtract steps of the shared divider. These
// hold busy until the result shows. The receiver cannot stall o_valid.
// Synchronous active-low reset clears the control state and sets rows and
// cols to 64; the pixel store is not cleared.
`default_nettype none

module grey_image_contrast_stretch #(
    parameter int MAX_PIXELS = 4096,
    parameter int PIXEL_BITS = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // command channel
    input  wire logic             start,
    output logic                  busy,
    input  wire gics_pkg::t_cmd   i_cmd,
    // result channel
    output logic                  o_valid,
    output gics_pkg::t_result     o_result,
    // APB register port
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [2:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int CW = $clog2(MAX_PIXELS + 1);
    localparam int SW = (CW > gics_pkg::SIZE_BITS) ? CW : gics_pkg::SIZE_BITS;
    localparam int XW = (AW > 12) ? AW : 12;
    localparam int PB = PIXEL_BITS;
    localparam int NW = PB + 9;

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    gics_pkg::t_state r_state, n_state;
    logic [6:0]       r_rows, r_cols;
    logic [CW-1:0]    r_count, n_count;
    logic [PB-1:0]    r_min, n_min, r_max, n_max;
    logic [NW-1:0]    r_rem, n_rem, r_den, n_den;
    logic [gics_pkg::QUOT_BITS-1:0] r_quot, n_quot;
    logic [gics_pkg::STEP_BITS-1:0] r_step, n_step;
    logic             r_valid, n_valid;
    gics_pkg::t_result r_result, n_result;

    logic [PB-1:0]    r_mem [MAX_PIXELS];
    logic [PB-1:0]    r_rd_data;

    // ---------------------------------------------------------------
    // frame size, clamped to the store depth
    // ---------------------------------------------------------------
    logic [gics_pkg::SIZE_BITS-1:0] w_prod;
    logic [SW-1:0]    w_size;
    logic             w_accept;
    logic             w_wr_en, w_rd_en;
    logic [AW-1:0]    w_wr_addr, w_rd_addr;
    logic [PB-1:0]    w_pix;
    logic [CW-1:0]    w_load_pos;
    logic [XW-1:0]    w_idx_x;
    logic             w_rd_err;

    assign w_prod = gics_pkg::SIZE_BITS'(r_rows) * gics_pkg::SIZE_BITS'(r_cols);
    assign w_size = (SW'(w_prod) > SW'(MAX_PIXELS)) ? SW'(MAX_PIXELS) : SW'(w_prod);

    assign busy     = (r_state != gics_pkg::S_IDLE);
    assign w_accept = start && !busy;
    assign w_pix    = i_cmd.pixel[PB-1:0];
    assign w_idx_x  = XW'(i_cmd.index);

    // load position after an optional restart
    assign w_load_pos = i_cmd.start_frame ? '0 : r_count;
    assign w_wr_en    = w_accept && (i_cmd.op == gics_pkg::OP_LOAD)
                        && (SW'(w_load_pos) < w_size);
    assign w_wr_addr  = w_load_pos[AW-1:0];

    // read check: frame complete and index in range
    assign w_rd_err  = (SW'(r_count) < w_size) || (SW'(i_cmd.index) >= w_size);
    assign w_rd_en   = w_accept && (i_cmd.op == gics_pkg::OP_READ) && !w_rd_err;
    assign w_rd_addr = w_idx_x[AW-1:0];

    // pixel store
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_pix;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // ---------------------------------------------------------------
    // numerator from the fetched pixel
    // ---------------------------------------------------------------
    logic [PB-1:0] w_span, w_clamp, w_diff;
    logic [NW-1:0] w_num;
    logic          w_flat;
    logic          w_fits;
    logic [NW-1:0] w_sub;

    assign w_flat  = (r_max <= r_min);
    assign w_span  = r_max - r_min;
    assign w_clamp = (r_rd_data < r_min) ? r_min :
                     (r_rd_data > r_max) ? r_max : r_rd_data;
    assign w_diff  = w_clamp - r_min;
    assign w_num   = NW'(w_diff) * NW'(gics_pkg::STRETCH_MUL) + NW'(w_span);

    // shared compare/subtract unit
    assign w_fits = (r_rem >= r_den);
    assign w_sub  = r_rem - r_den;

    // ---------------------------------------------------------------
    // sequencer and load bookkeeping
    // ---------------------------------------------------------------
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_min    = r_min;
        n_max    = r_max;
        n_rem    = r_rem;
        n_den    = r_den;
        n_quot   = r_quot;
        n_step   = r_step;
        n_valid  = 1'b0;
        n_result = r_result;

        case (r_state)
            gics_pkg::S_IDLE: begin
                if (w_accept && (i_cmd.op == gics_pkg::OP_LOAD)) begin
                    n_count = w_load_pos;
                    if (w_wr_en) begin
                        n_count = w_load_pos + CW'(1);
                        if (w_load_pos == '0) begin
                            n_min = w_pix;
                            n_max = w_pix;
                        end else begin
                            if (w_pix < r_min) n_min = w_pix;
                            if (w_pix > r_max) n_max = w_pix;
                        end
                    end
                end else if (w_accept) begin
                    if (w_rd_err) begin
                        n_valid        = 1'b1;
                        n_result.value = '0;
                        n_result.error = 1'b1;
                    end else begin
                        n_state = gics_pkg::S_FETCH;
                    end
                end
            end
            gics_pkg::S_FETCH: begin
                if (w_flat) begin
                    n_valid        = 1'b1;
                    n_result.value = 16'(r_rd_data);
                    n_result.error = 1'b0;
                    n_state        = gics_pkg::S_IDLE;
                end else begin
                    // divisor 2*d aligned to the top quotient bit
                    n_rem   = w_num;
                    n_den   = NW'(w_span) << gics_pkg::QUOT_BITS;
                    n_quot  = '0;
                    n_step  = '0;
                    n_state = gics_pkg::S_DIV;
                end
            end
            gics_pkg::S_DIV: begin
                if (w_fits) begin
                    n_rem = w_sub;
                end
                n_quot = {r_quot[gics_pkg::QUOT_BITS-2:0], w_fits};
                n_den  = r_den >> 1;
                n_step = r_step + 1'b1;
                if (r_step == gics_pkg::STEP_BITS'(gics_pkg::QUOT_BITS - 1)) begin
                    n_valid        = 1'b1;
                    n_result.value = 16'(n_quot);
                    n_result.error = 1'b0;
                    n_state        = gics_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gics_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gics_pkg::S_IDLE;
            r_count <= '0;
            r_min   <= '0;
            r_max   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_min   <= n_min;
            r_max   <= n_max;
            r_valid <= n_valid;
        end
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        r_rem    <= n_rem;
        r_den    <= n_den;
        r_quot   <= n_quot;
        r_step   <= n_step;
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    // ---------------------------------------------------------------
    // APB registers
    // ---------------------------------------------------------------
    logic w_cfg_wr;
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= gics_pkg::ROWS_RESET;
            r_cols <= gics_pkg::COLS_RESET;
        end else if (w_cfg_wr) begin
            if (paddr[2] == gics_pkg::REG_ROWS) begin
                r_rows <= pwdata[6:0];
            end else begin
                r_cols <= pwdata[6:0];
            end
        end
    end

    always_comb begin
        case (paddr[2])
            gics_pkg::REG_ROWS: prdata = 32'(r_rows);
            gics_pkg::REG_COLS: prdata = 32'(r_cols);
            default:            prdata = '0;
        endcase
    end

endmodule : grey_image_contrast_stretch

`default_nettype wire

FILE: tb/tb_grey_image_contrast_stretch.sv
// Self-checking bench for grey_image_contrast_stretch: loads frames, reads
// stretched pixels and checks every result word against its own prediction.
// Depends on gics_pkg and the grey_image_contrast_stretch top level.
`default_nettype none

module tb_grey_image_contrast_stretch;

    localparam int          FRAME_CAP     = 4096;
    localparam int          SETTLE_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int          RANDOM_WORDS  = 1400;

    // Stretch predictor plus queue of result words still owed by the block
    class stretch_scoreboard;
        bit [15:0]   frame_mem [FRAME_CAP];
        bit [15:0]   lo_px;
        bit [15:0]   hi_px;
        int unsigned loaded;
        int unsigned rows;
        int unsigned cols;
        gics_pkg::t_result awaited [$];
        int unsigned fail_count;
        int unsigned load_words;
        int unsigned read_words;
        int unsigned stretched_reads;
        int unsigned flat_reads;
        int unsigned flagged_reads;

        function new();
            lo_px  = '0;
            hi_px  = '0;
            loaded = 0;
            rows   = gics_pkg::ROWS_RESET;
            cols   = gics_pkg::COLS_RESET;
        endfunction

        function void write_reg(logic idx, bit [31:0] val);
            if (idx == gics_pkg::REG_ROWS) begin
                rows = val[6:0];
            end else begin
                cols = val[6:0];
            end
        endfunction

        function int unsigned frame_pixels();
            int unsigned n;
            n = rows * cols;
            return (n > FRAME_CAP) ? FRAME_CAP : n;
        endfunction

        // round half up of (v-lo)*255/(hi-lo); a flat frame passes v through
        function bit [15:0] stretch_px(bit [15:0] v);
            int unsigned span;
            int unsigned num;
            bit [15:0]   c;
            if (hi_px <= lo_px) begin
                return v;
            end
            c = v;
            if (c < lo_px) c = lo_px;
            if (c > hi_px) c = hi_px;
            span = hi_px - lo_px;
            num  = 2 * (c - lo_px) * gics_pkg::STRETCH_TOP + span;
            return 16'(num / (2 * span));
        endfunction

        // Called for every accepted command word
        function void note_cmd(gics_pkg::t_cmd c);
            int unsigned size;
            gics_pkg::t_result r;
            size = frame_pixels();
            if (c.op == gics_pkg::OP_LOAD) begin
                load_words++;
                if (c.start_frame) loaded = 0;
                if (loaded < size) begin
                    frame_mem[loaded] = c.pixel;
                    if (loaded == 0) begin
                        lo_px = c.pixel;
                        hi_px = c.pixel;
                    end else begin
                        if (c.pixel < lo_px) lo_px = c.pixel;
                        if (c.pixel > hi_px) hi_px = c.pixel;
                    end
                    loaded++;
                end
            end else begin
                read_words++;
                if (loaded < size || c.index >= size) begin
                    r.value = '0;
                    r.error = 1'b1;
                    flagged_reads++;
                end else begin
                    r.value = stretch_px(frame_mem[c.index]);
                    r.error = 1'b0;
                    if (hi_px <= lo_px) flat_reads++;
                    else stretched_reads++;
                end
                awaited.insert(awaited.size(), r);
            end
        endfunction

        // Called for every result word under o_valid
        function void check_result(gics_pkg::t_result got);
            gics_pkg::t_result want;
            if (awaited.size() == 0) begin
                $error("result word with nothing pending: value %0h error %0b",
                       got.value, got.error);
                fail_count++;
                return;
            end
            want = awaited.pop_front();
            if (got.value !== want.value) begin
                $error("value mismatch: expected %0h, got %0h", want.value, got.value);
                fail_count++;
            end
            if (got.error !== want.error) begin
                $error("error mismatch: expected %0b, got %0b", want.error, got.error);
                fail_count++;
            end
        endfunction
    endclass

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        start    = 1'b0;
    logic        busy;
    gics_pkg::t_cmd    cmd_word = '0;
    logic        o_valid;
    gics_pkg::t_result o_result;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    stretch_scoreboard sb = new();
    bit          gaps_on    = 1'b1;
    int unsigned sent_count = 0;
    int unsigned setups     = 0;
    int unsigned cycle_count;

    grey_image_contrast_stretch uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (cmd_word),
        .o_valid  (o_valid),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Accept and result monitor; sees pre-edge values
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) sb.note_cmd(cmd_word);
            if (o_valid) sb.check_result(o_result);
        end
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d words pending", cycle_count,
                 sb.awaited.size());
        $display("tb: failure");
        $finish;
    end

    // Present one command word; each cycle ahead of it idles with about 34% odds
    task automatic send_cmd(input gics_pkg::t_cmd c);
        if (gaps_on) begin
            while ($urandom_range(99) < 34) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start    <= 1'b1;
        cmd_word <= c;
        do @(posedge i_clk); while (busy);
        sent_count++;
    endtask

    task automatic load_px(input bit restart, input bit [15:0] px);
        gics_pkg::t_cmd c;
        c.op          = gics_pkg::OP_LOAD;
        c.start_frame = restart;
        c.pixel       = px;
        c.index       = 12'($urandom);
        send_cmd(c);
    endtask

    // start_frame and pixel are don't-care on a read, so randomize them
    task automatic read_px(input bit [11:0] idx);
        gics_pkg::t_cmd c;
        c.op          = gics_pkg::OP_READ;
        c.start_frame = 1'($urandom);
        c.pixel       = 16'($urandom);
        c.index       = idx;
        send_cmd(c);
    endtask

    // Let all owed results arrive, then allow the datapath to settle
    task automatic drain();
        start <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write, only once the block is idle
    task automatic set_reg(input logic idx, input bit [31:0] val);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    function automatic int unsigned pick_dim();
        int unsigned k;
        k = $urandom_range(0, 19);
        if (k == 0) return 0;
        if (k == 1) return 127;
        if (k == 2) return 64;
        return $urandom_range(1, 8);
    endfunction

    function automatic bit [11:0] pick_index(int unsigned size);
        if (size > 0 && $urandom_range(0, 9) < 7) return 12'($urandom_range(0, size - 1));
        return 12'($urandom);
    endfunction

    // One random frame: setup, loads (sometimes broken up), then reads
    task automatic run_frame();
        int unsigned r;
        int unsigned c;
        int unsigned size;
        int unsigned i;
        int unsigned n;
        int unsigned spread;
        bit [15:0]   base;
        bit          broken;
        bit          restarted;
        r = pick_dim();
        c = pick_dim();
        if (r * c > 256) c = $urandom_range(0, 2);
        set_reg(gics_pkg::REG_ROWS, r);
        set_reg(gics_pkg::REG_COLS, c);
        setups++;
        size = sb.frame_pixels();

        // pixel window: full range, narrow, flat or medium
        case ($urandom_range(0, 3))
            0: spread = 16'hFFFF;
            1: spread = $urandom_range(1, 4);
            2: spread = 0;
            default: spread = $urandom_range(5, 2000);
        endcase
        base      = 16'($urandom_range(0, 65535 - spread));
        broken    = ($urandom_range(0, 9) < 3);
        restarted = 1'b0;

        i = 0;
        while (i < size || (size == 0 && i == 0)) begin
            if (broken && i > 0 && $urandom_range(0, 19) == 0) begin
                read_px(pick_index(size));
            end
            if (broken && !restarted && i == size / 2 && i > 0) begin
                restarted = 1'b1;
                i = 0;
            end
            load_px(i == 0, base + 16'($urandom_range(0, spread)));
            i++;
        end
        // loads past the end of the frame are dropped
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) load_px(1'b0, 16'($urandom));
        end

        n = $urandom_range(4, 16);
        repeat (n) read_px(pick_index(size));

        // frame size changed under a loaded frame
        if ($urandom_range(0, 4) == 0) begin
            if ($urandom_range(0, 1) == 1) begin
                set_reg(gics_pkg::REG_COLS, $urandom_range(0, 8));
            end else begin
                set_reg(gics_pkg::REG_ROWS, $urandom_range(0, 8));
            end
            size = sb.frame_pixels();
            repeat ($urandom_range(2, 6)) read_px(pick_index(size));
        end
    endtask

    initial begin
        int unsigned quiet_from;
        int unsigned random_from;
        int unsigned k;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reads before any frame is loaded
        read_px(12'd0);
        read_px(12'hFFF);

        // 2x3 frame with extreme pixels
        set_reg(gics_pkg::REG_ROWS, 2);
        set_reg(gics_pkg::REG_COLS, 3);
        load_px(1'b1, 16'hFFFF);
        load_px(1'b0, 16'h0000);
        load_px(1'b0, 16'h8000);
        load_px(1'b0, 16'h7FFF);
        load_px(1'b0, 16'h0001);
        load_px(1'b0, 16'hFFFE);
        for (k = 0; k < 6; k++) read_px(12'(k));
        read_px(12'd6);
        read_px(12'hFFF);
        // excess load is dropped
        load_px(1'b0, 16'h1234);
        read_px(12'd2);
        // shrink frame under a complete frame
        set_reg(gics_pkg::REG_COLS, 2);
        read_px(12'd3);
        read_px(12'd5);
        // restart leaves frame incomplete
        load_px(1'b1, 16'h0040);
        read_px(12'd0);

        // flat single-pixel frame returns raw value
        set_reg(gics_pkg::REG_ROWS, 1);
        set_reg(gics_pkg::REG_COLS, 1);
        load_px(1'b1, 16'hABCD);
        read_px(12'd0);

        // half-way rounding: span 2, middle pixel lands on 127.5
        set_reg(gics_pkg::REG_COLS, 3);
        load_px(1'b1, 16'd10);
        load_px(1'b0, 16'd11);
        load_px(1'b0, 16'd12);
        read_px(12'd1);

        // zero-sized frame: loads dropped, reads flagged
        set_reg(gics_pkg::REG_ROWS, 0);
        load_px(1'b1, 16'h5555);
        read_px(12'd0);

        // largest frame: 127 x 64 clamps to the store depth, a partial load
        // leaves it incomplete
        set_reg(gics_pkg::REG_ROWS, 127);
        set_reg(gics_pkg::REG_COLS, 64);
        setups++;
        for (k = 0; k < 8; k++) load_px(k == 0, 16'($urandom));
        read_px(12'd0);
        read_px(12'hFFF);
        repeat (6) read_px(12'($urandom));

        // Random frames, with one stretch free of gaps
        random_from = sent_count;
        quiet_from  = random_from + 500;
        while (sent_count - random_from < RANDOM_WORDS) begin
            gaps_on = !(sent_count >= quiet_from && sent_count < quiet_from + 300);
            run_frame();
        end

        drain();
        $display("sent %0d words (%0d loads, %0d reads) across %0d frame setups",
                 sent_count, sb.load_words, sb.read_words, setups);
        $display("reads: %0d stretched, %0d flat, %0d flagged",
                 sb.stretched_reads, sb.flat_reads, sb.flagged_reads);
        if (sb.fail_count == 0 && sb.awaited.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
